// File: src/rfft_pkg.sv
package rfft_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int ADDR_W = 12;
  localparam int DATA_W = 24;
  localparam int TW_W = 18;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] bin_re;
    logic signed [23:0] bin_im;
    logic               is_last;
  } out_word_t;

  typedef enum logic [1:0] {
    CFG_INVERSE_MODE = 2'd0,
    CFG_LOG2_SIZE    = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic              valid;
    logic [3:0]        log2n;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [47:0]       data;
  } wr_req_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_BR_RD,
    C_BR_WA,
    C_BR_WB,
    C_BF_RD,
    C_BF_MUL,
    C_BF_WP,
    C_BF_WQ,
    C_OUT_RD,
    C_OUT_LD
  } core_state_t;

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > 28'sd8388607) r = 24'sh7FFFFF;
    else if (v < -28'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // truncating division by shift and subtract, elaboration only
  function automatic longint div_trunc(input longint a, input longint d);
    longint ua;
    longint ud;
    longint q;
    longint rem;
    bit     neg;
    neg = (a < 0) != (d < 0);
    ua  = (a < 0) ? -a : a;
    ud  = (d < 0) ? -d : d;
    q   = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem << 1) | ((ua >>> b) & longint'(1));
      if (rem >= ud) begin
        rem = rem - ud;
        q   = q | (longint'(1) << b);
      end
    end
    return neg ? -q : q;
  endfunction

  // q2.16 cos or sin of 2*pi*idx/2^lg, used at elaboration only
  function automatic longint tw_q16(input int idx, input int lg, input bit want_sin);
    longint k;
    longint x;
    longint x2;
    longint term;
    longint cs;
    longint sn;
    bit     neg;
    k   = idx;
    neg = 1'b0;
    if (4 * k > (longint'(1) << lg)) begin
      k   = (longint'(1) << (lg - 1)) - k;
      neg = 1'b1;
    end
    x    = (2 * PI_Q30 * k) >>> lg;
    x2   = div_trunc(x * x, ONE_Q30);
    term = ONE_Q30;
    cs   = ONE_Q30;
    for (int i = 1; i <= 8; i++) begin
      term = div_trunc(-div_trunc(term * x2, ONE_Q30), longint'((2 * i - 1) * (2 * i)));
      cs   = cs + term;
    end
    term = x;
    sn   = x;
    for (int i = 1; i <= 8; i++) begin
      term = div_trunc(-div_trunc(term * x2, ONE_Q30), longint'((2 * i) * (2 * i + 1)));
      sn   = sn + term;
    end
    cs = (cs + 8192) >>> 14;
    sn = (sn + 8192) >>> 14;
    if (want_sin) return sn;
    return neg ? -cs : cs;
  endfunction

endpackage

// File: src/rfft_load.sv
module rfft_load #(
  parameter int MAX_POINTS = rfft_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rfft_pkg::in_word_t in_data,
  input  logic [2:0]         log2_size,
  input  logic               back_free,
  output rfft_pkg::job_t     push,
  output rfft_pkg::wr_req_t  wr
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;
  localparam logic [3:0] LMAX = 4'(AW);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    l_eff;
  logic [CW-1:0] n_w;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_inc;
  logic          accept;

  assign l_eff   = ({1'b0, log2_size} > LMAX) ? LMAX : {1'b0, log2_size};
  assign n_w     = CW'(1) << l_eff;
  assign idx     = (cnt_r >= n_w) ? '0 : cnt_r;
  assign idx_inc = idx + CW'(1);
  assign in_ready = back_free;
  assign accept  = in_valid && in_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = (idx_inc == n_w) ? '0 : idx_inc;
    end
    push.valid = accept && (idx_inc == n_w);
    push.log2n = l_eff;
    wr.en      = accept;
    wr.addr    = rfft_pkg::ADDR_W'(idx);
    wr.data    = {{8{in_data.sample_re[15]}}, in_data.sample_re,
                  {8{in_data.sample_im[15]}}, in_data.sample_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: src/rfft_jobq.sv
module rfft_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  rfft_pkg::job_t push,
  input  logic           pop,
  output rfft_pkg::job_t head,
  output logic           empty
);

  logic [3:0] ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign do_push    = push.valid && (cnt_r != 2'd2);
  assign do_pop     = pop && (cnt_r != 2'd0);
  assign empty      = (cnt_r == 2'd0);
  assign head.valid = !empty;
  assign head.log2n = ent_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push.log2n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: src/rfft_core.sv
module rfft_core #(
  parameter int MAX_POINTS = rfft_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rfft_pkg::job_t      job,
  output logic                job_pop,
  input  logic                inverse_mode,
  input  rfft_pkg::wr_req_t   ld_wr,
  output logic                idle,
  output logic                out_valid,
  input  logic                out_ready,
  output rfft_pkg::out_word_t out_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int TW = rfft_pkg::TW_W;

  rfft_pkg::core_state_t state_r, state_nxt;

  logic [47:0] mem [MAX_POINTS];
  logic [47:0] rd_a_r, rd_b_r;
  logic [AW-1:0] addr_a, addr_b, wr_addr;
  logic [47:0] wr_data;
  logic        wr_en;

  logic [AW-1:0] i_r, i_nxt;
  logic [3:0]    s_r, s_nxt;
  logic [3:0]    l_r, l_nxt;
  logic          inv_r, inv_nxt;

  logic signed [TW-1:0] cos_rom [MAX_POINTS];
  logic signed [TW-1:0] sin_rom [MAX_POINTS];
  logic signed [TW-1:0] c_r, wi_r;
  logic signed [41:0]   pm_rc_r, pm_ib_r, pm_rw_r, pm_ic_r;
  logic [47:0]          qres_r;

  rfft_pkg::out_word_t out_r;
  logic                out_valid_r;
  logic                out_load;

  logic [AW:0]   n_w;
  logic [AW-1:0] last_idx, last_bf;
  logic [AW-1:0] rev_full, rev_i;
  logic [AW-1:0] half, p_a, q_a, j_a, tw_idx;

  logic signed [43:0] sum_r44, sum_i44;
  logic signed [27:0] vr, vi, ur, ui;
  logic signed [23:0] ap_re, ap_im, bq_re, bq_im;
  logic signed [24:0] sc_re, sc_im, rnd;
  logic signed [23:0] o_re, o_im;
  logic               scale;

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_rom
    assign cos_rom[g] = TW'(rfft_pkg::tw_q16(g, AW, 1'b0));
    assign sin_rom[g] = TW'(rfft_pkg::tw_q16(g, AW, 1'b1));
  end

  always_comb begin
    n_w      = (AW + 1)'(1) << l_r;
    last_idx = AW'(n_w - (AW + 1)'(1));
    last_bf  = AW'((n_w >> 1) - (AW + 1)'(1));
    for (int b = 0; b < AW; b++) begin
      rev_full[AW-1-b] = i_r[b];
    end
    rev_i  = rev_full >> (4'(AW) - l_r);
    half   = AW'(1) << (s_r - 4'd1);
    j_a    = i_r & (half - AW'(1));
    p_a    = ((i_r >> (s_r - 4'd1)) << s_r) | j_a;
    q_a    = p_a | half;
    tw_idx = AW'(j_a << (4'(AW) - s_r));
  end

  // butterfly sums
  always_comb begin
    sum_r44 = 44'(pm_rc_r) - 44'(pm_ib_r) + 44'sd32768;
    sum_i44 = 44'(pm_rw_r) + 44'(pm_ic_r) + 44'sd32768;
    vr      = 28'(sum_r44 >>> 16);
    vi      = 28'(sum_i44 >>> 16);
    ur      = 28'($signed(rd_a_r[47:24]));
    ui      = 28'($signed(rd_a_r[23:0]));
    ap_re   = rfft_pkg::sat24(ur + vr);
    ap_im   = rfft_pkg::sat24(ui + vi);
    bq_re   = rfft_pkg::sat24(ur - vr);
    bq_im   = rfft_pkg::sat24(ui - vi);
  end

  // inverse scaling on the way out
  always_comb begin
    scale = inv_r && (l_r != 4'd0);
    rnd   = scale ? (25'sd1 <<< (l_r - 4'd1)) : 25'sd0;
    sc_re = (25'($signed(rd_a_r[47:24])) + rnd) >>> (scale ? l_r : 4'd0);
    sc_im = (25'($signed(rd_a_r[23:0])) + rnd) >>> (scale ? l_r : 4'd0);
    o_re  = sc_re[23:0];
    o_im  = sc_im[23:0];
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    s_nxt     = s_r;
    l_nxt     = l_r;
    inv_nxt   = inv_r;
    job_pop   = 1'b0;
    out_load  = 1'b0;
    addr_a    = i_r;
    addr_b    = rev_i;
    wr_en     = ld_wr.en;
    wr_addr   = AW'(ld_wr.addr);
    wr_data   = ld_wr.data;
    unique case (state_r)
      rfft_pkg::C_IDLE: begin
        if (job.valid) begin
          job_pop   = 1'b1;
          l_nxt     = job.log2n;
          inv_nxt   = inverse_mode;
          i_nxt     = '0;
          state_nxt = (job.log2n == 4'd0) ? rfft_pkg::C_OUT_RD : rfft_pkg::C_BR_RD;
        end
      end
      rfft_pkg::C_BR_RD: begin
        if (i_r < rev_i) begin
          state_nxt = rfft_pkg::C_BR_WA;
        end else if (i_r == last_idx) begin
          i_nxt     = '0;
          s_nxt     = 4'd1;
          state_nxt = rfft_pkg::C_BF_RD;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      rfft_pkg::C_BR_WA: begin
        wr_en     = 1'b1;
        wr_addr   = i_r;
        wr_data   = rd_b_r;
        state_nxt = rfft_pkg::C_BR_WB;
      end
      rfft_pkg::C_BR_WB: begin
        wr_en   = 1'b1;
        wr_addr = rev_i;
        wr_data = rd_a_r;
        if (i_r == last_idx) begin
          i_nxt     = '0;
          s_nxt     = 4'd1;
          state_nxt = rfft_pkg::C_BF_RD;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = rfft_pkg::C_BR_RD;
        end
      end
      rfft_pkg::C_BF_RD: begin
        addr_a    = p_a;
        addr_b    = q_a;
        state_nxt = rfft_pkg::C_BF_MUL;
      end
      rfft_pkg::C_BF_MUL: begin
        addr_a    = p_a;
        addr_b    = q_a;
        state_nxt = rfft_pkg::C_BF_WP;
      end
      rfft_pkg::C_BF_WP: begin
        addr_a    = p_a;
        addr_b    = q_a;
        wr_en     = 1'b1;
        wr_addr   = p_a;
        wr_data   = {ap_re, ap_im};
        state_nxt = rfft_pkg::C_BF_WQ;
      end
      rfft_pkg::C_BF_WQ: begin
        addr_a  = p_a;
        addr_b  = q_a;
        wr_en   = 1'b1;
        wr_addr = q_a;
        wr_data = qres_r;
        if (i_r == last_bf) begin
          i_nxt = '0;
          if (s_r == l_r) begin
            state_nxt = rfft_pkg::C_OUT_RD;
          end else begin
            s_nxt     = s_r + 4'd1;
            state_nxt = rfft_pkg::C_BF_RD;
          end
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = rfft_pkg::C_BF_RD;
        end
      end
      rfft_pkg::C_OUT_RD: begin
        state_nxt = rfft_pkg::C_OUT_LD;
      end
      rfft_pkg::C_OUT_LD: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (i_r == last_idx) begin
            state_nxt = rfft_pkg::C_IDLE;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = rfft_pkg::C_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = rfft_pkg::C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (state_r == rfft_pkg::C_BF_RD) begin
      c_r  <= cos_rom[tw_idx];
      wi_r <= inv_r ? sin_rom[tw_idx] : -sin_rom[tw_idx];
    end
    if (state_r == rfft_pkg::C_BF_MUL) begin
      pm_rc_r <= $signed(rd_b_r[47:24]) * c_r;
      pm_ib_r <= $signed(rd_b_r[23:0]) * wi_r;
      pm_rw_r <= $signed(rd_b_r[47:24]) * wi_r;
      pm_ic_r <= $signed(rd_b_r[23:0]) * c_r;
    end
    if (state_r == rfft_pkg::C_BF_WP) begin
      qres_r <= {bq_re, bq_im};
    end
    if (out_load) begin
      out_r.bin_re  <= o_re;
      out_r.bin_im  <= o_im;
      out_r.is_last <= (i_r == last_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfft_pkg::C_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      s_r         <= 4'd0;
      l_r         <= 4'd0;
      inv_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      s_r     <= s_nxt;
      l_r     <= l_nxt;
      inv_r   <= inv_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign idle      = (state_r == rfft_pkg::C_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/radix2_fft.sv
// radix-2 decimation-in-time fft / inverse fft, fixed point
// input channel: one complex 16-bit sample word per in_valid/in_ready handshake.
// once 2^log2_size samples (log2_size capped at log2 of MAX_POINTS) are loaded
// the transform runs on the work memory: a bit-reversal pass (a read per
// index, and a write of both entries when they swap), then log2_size stages
// of n/2 butterflies, each read, multiplied and written back in turn (one
// shared complex multiplier, one memory write port), then n output words,
// each read and loaded into the output register; in_ready is low from the
// last sample of a frame until the last coefficient reaches the output register.
// output channel: bin_re, bin_im in natural order, is_last on the final one,
// inverse results scaled by 1/n with rounding.
// a stalled receiver holds the output register and the back end waits;
// loading of the next frame starts once the back end is free again.
// configuration: cfg_index 0 inverse_mode, 1 log2_size; cfg_ready is always
// high. reset clears the load count, the job queue and the output valid flag,
// and sets forward mode and log2_size 6; the work memory is not cleared.
module radix2_fft #(
  parameter int MAX_POINTS = rfft_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rfft_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rfft_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [2:0]          cfg_data
);

  logic              inverse_mode_r;
  logic [2:0]        log2_size_r;
  rfft_pkg::job_t    push;
  rfft_pkg::job_t    head;
  rfft_pkg::wr_req_t ld_wr;
  logic              q_empty;
  logic              job_pop;
  logic              core_idle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inverse_mode_r <= 1'b0;
      log2_size_r    <= 3'd6;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rfft_pkg::CFG_INVERSE_MODE) begin
        inverse_mode_r <= cfg_data[0];
      end else if (cfg_index == rfft_pkg::CFG_LOG2_SIZE) begin
        log2_size_r <= cfg_data;
      end
    end
  end

  rfft_load #(.MAX_POINTS(MAX_POINTS)) u_load (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .log2_size (log2_size_r),
    .back_free (core_idle && q_empty),
    .push      (push),
    .wr        (ld_wr)
  );

  rfft_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (job_pop),
    .head  (head),
    .empty (q_empty)
  );

  rfft_core #(.MAX_POINTS(MAX_POINTS)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .job          (head),
    .job_pop      (job_pop),
    .inverse_mode (inverse_mode_r),
    .ld_wr        (ld_wr),
    .idle         (core_idle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

// File: src/rfft_checker.sv
module rfft_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rfft_pkg::out_word_t out_data
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // no loading while a transform still has coefficients to send
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_last |-> !in_ready)
    else $error("input open during output phase");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind radix2_fft rfft_checker u_rfft_checker (.*);
